>>> rtl/mops_pkg.sv
`default_nettype none

package mops_pkg;

  // Default sizes of the table and of the keys.
  localparam int MAX_KEYS_DEF    = 4;
  localparam int HASH_BITS_DEF   = 32;
  localparam int TABLE_DEPTH_DEF = 64;

  // Fixed widths of the port fields.
  localparam int INPUT_KEYS  = 4;
  localparam int HASH_IN_W   = 32;
  localparam int VALID_IN_W  = 6;
  localparam int SLOT_W      = 6;
  localparam int COUNT_W     = 7;
  localparam int POS_W       = 7;
  localparam int KEY_COUNT_W = 3;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes, taken from the word address.
  localparam logic REG_KEY_COUNT = 1'b0;

  localparam logic [KEY_COUNT_W-1:0] KEY_COUNT_RESET = 3'd2;

  // Item kinds.
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  // Search sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_EXPAND,
    ST_CMP,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

>>> rtl/mops_ram.sv
`default_nettype none

module mops_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/mops_expand.sv
`default_nettype none

module mops_expand #(
  parameter int MAX_KEYS  = 4,
  parameter int HASH_BITS = 32,
  parameter int VALID_W   = 6,
  parameter int KEY_W     = 3,
  parameter int LEN_W     = 8
) (
  input  wire logic                            clk,
  input  wire logic                            load,
  input  wire logic [KEY_W-1:0]                key_num,
  input  wire logic [MAX_KEYS*HASH_BITS-1:0]   hash_vec,
  input  wire logic [MAX_KEYS*VALID_W-1:0]     valid_vec,
  output      logic [MAX_KEYS*HASH_BITS-1:0]   morton,
  output      logic [LEN_W-1:0]                len
);

  localparam int MW = MAX_KEYS * HASH_BITS;

  logic [MW-1:0]    morton_next;
  logic [LEN_W-1:0] len_next;

  // Interleave the hashes, most significant bit first, key by key.
  // Position p of the Morton value sits at bit MW-1-p, so plain numeric
  // order of the vectors is Morton order.
  always_comb begin
    morton_next = '0;
    for (int nn = 1; nn <= MAX_KEYS; nn++) begin
      if (key_num == KEY_W'(nn)) begin
        for (int i = 0; i < HASH_BITS; i++) begin
          for (int j = 0; j < nn; j++) begin
            morton_next[MW-1-(i*nn+j)] = hash_vec[j*HASH_BITS + HASH_BITS-1-i];
          end
        end
      end
    end
  end

  // The bit length is the first position whose key has no valid bit left.
  always_comb begin
    logic [VALID_W-1:0] vj;
    logic [LEN_W-1:0]   pos;
    len_next = LEN_W'(key_num) * LEN_W'(HASH_BITS);
    for (int j = 0; j < MAX_KEYS; j++) begin
      vj  = valid_vec[j*VALID_W +: VALID_W];
      pos = LEN_W'(vj) * LEN_W'(key_num) + LEN_W'(j);
      if ((KEY_W'(j) < key_num) && (vj < VALID_W'(HASH_BITS)) && (pos < len_next)) begin
        len_next = pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      morton <= morton_next;
      len    <= len_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/morton_order_page_search_core.sv
`default_nettype none

// Channel | Handshake           | Word
// --------+---------------------+----------------------------------------------
// input   | in_valid / in_stall | kind, slot, hash_0..3, valid_0..3,
//         |                     | full_compare, entry_count
// output  | out_valid/out_stall | found, position
// config  | APB write/read      | key_count at byte address 0
//
// A load word is written to the table in the cycle it is accepted.
// A search starts, then probes the table (read, expand, compare for each
// probe) until the range is empty or hit, and finishes through a done state.
// The probe loop through the table memory sets the length of a search.
// Reset is synchronous; it clears the sequencer and the output register and
// sets key_count to 2. The table is not cleared.
// The input is stalled while a search runs; a finished result waits in the
// output register, and the next word is taken while it waits.
module morton_order_page_search_core #(
  parameter int MAX_KEYS    = mops_pkg::MAX_KEYS_DEF,
  parameter int HASH_BITS   = mops_pkg::HASH_BITS_DEF,
  parameter int TABLE_DEPTH = mops_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,

  input  wire logic                               in_valid,
  output      logic                               in_stall,
  input  wire logic                               kind,
  input  wire logic [mops_pkg::SLOT_W-1:0]        slot,
  input  wire logic [mops_pkg::HASH_IN_W-1:0]     hash_0,
  input  wire logic [mops_pkg::HASH_IN_W-1:0]     hash_1,
  input  wire logic [mops_pkg::HASH_IN_W-1:0]     hash_2,
  input  wire logic [mops_pkg::HASH_IN_W-1:0]     hash_3,
  input  wire logic [mops_pkg::VALID_IN_W-1:0]    valid_0,
  input  wire logic [mops_pkg::VALID_IN_W-1:0]    valid_1,
  input  wire logic [mops_pkg::VALID_IN_W-1:0]    valid_2,
  input  wire logic [mops_pkg::VALID_IN_W-1:0]    valid_3,
  input  wire logic                               full_compare,
  input  wire logic [mops_pkg::COUNT_W-1:0]       entry_count,

  output      logic                               out_valid,
  input  wire logic                               out_stall,
  output      logic                               found,
  output      logic [mops_pkg::POS_W-1:0]         position,

  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [mops_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [mops_pkg::CFG_DATA_W-1:0]    pwdata,
  output      logic [mops_pkg::CFG_DATA_W-1:0]    prdata,
  output      logic                               pready
);

  import mops_pkg::*;

  localparam int MW      = MAX_KEYS * HASH_BITS;
  localparam int VALID_W = $clog2(HASH_BITS + 1);
  localparam int KEY_W   = $clog2(MAX_KEYS + 1);
  localparam int LEN_W   = $clog2(MW + 1);
  localparam int ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);

  // Configuration register.
  logic [KEY_COUNT_W-1:0] key_count;
  logic [KEY_W-1:0]       key_num;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= KEY_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_KEY_COUNT)) begin
      key_count <= pwdata[KEY_COUNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_KEY_COUNT) ? CFG_DATA_W'(key_count) : '0;

  // Zero keys act as one, and counts above the limit as the limit.
  always_comb begin
    if (key_count == '0) begin
      key_num = KEY_W'(1);
    end else if (32'(key_count) > MAX_KEYS) begin
      key_num = KEY_W'(MAX_KEYS);
    end else begin
      key_num = KEY_W'(key_count);
    end
  end

  // Gather the input keys: hashes cut to the hash width, counts saturated.
  logic [HASH_IN_W-1:0]       in_hash  [INPUT_KEYS];
  logic [VALID_IN_W-1:0]      in_vcnt  [INPUT_KEYS];
  logic [MW-1:0]              hash_vec;
  logic [MAX_KEYS*VALID_W-1:0] valid_vec;

  assign in_hash[0] = hash_0;
  assign in_hash[1] = hash_1;
  assign in_hash[2] = hash_2;
  assign in_hash[3] = hash_3;
  assign in_vcnt[0] = valid_0;
  assign in_vcnt[1] = valid_1;
  assign in_vcnt[2] = valid_2;
  assign in_vcnt[3] = valid_3;

  for (genvar j = 0; j < MAX_KEYS; j++) begin : g_key
    if (j < INPUT_KEYS) begin : g_port
      assign hash_vec[j*HASH_BITS +: HASH_BITS] = HASH_BITS'(64'(in_hash[j]));
      assign valid_vec[j*VALID_W +: VALID_W] = (32'(in_vcnt[j]) > HASH_BITS) ?
                                               VALID_W'(HASH_BITS) : VALID_W'(in_vcnt[j]);
    end else begin : g_none
      assign hash_vec[j*HASH_BITS +: HASH_BITS] = '0;
      assign valid_vec[j*VALID_W +: VALID_W]    = '0;
    end
  end

  // Sequencer state and search bounds.
  state_t           state, state_next;
  logic [CNT_W-1:0] lo, lo_next;
  logic [CNT_W-1:0] hx, hx_next;
  logic [CNT_W-1:0] mid, mid_next;
  logic [CNT_W-1:0] mid_calc;
  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] count_sat;
  logic             res_found, res_found_next;
  logic [CNT_W-1:0] res_pos, res_pos_next;
  logic             full_q;
  logic             rd_en;
  logic             out_load;
  logic             in_accept;
  logic             load_wr;
  logic             query_load;

  assign in_stall   = (state != ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign load_wr    = in_accept && (kind == KIND_LOAD) && (32'(slot) < TABLE_DEPTH);
  assign query_load = in_accept && (kind == KIND_SEARCH);

  assign count_sat = (32'(entry_count) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                      : CNT_W'(entry_count);
  assign mid_sum   = {1'b0, lo} + {1'b0, hx} - 1'b1;
  assign mid_calc  = CNT_W'(mid_sum >> 1);

  // Entry table: hashes and valid counts, read at the probe address.
  logic [MW-1:0]               ram_hash;
  logic [MAX_KEYS*VALID_W-1:0] ram_valid;

  mops_ram #(
    .WIDTH (MW),
    .DEPTH (TABLE_DEPTH)
  ) u_hash_ram (
    .clk   (clk),
    .we    (load_wr),
    .waddr (ADDR_W'(slot)),
    .wdata (hash_vec),
    .re    (rd_en),
    .raddr (ADDR_W'(mid_calc)),
    .rdata (ram_hash)
  );

  mops_ram #(
    .WIDTH (MAX_KEYS * VALID_W),
    .DEPTH (TABLE_DEPTH)
  ) u_valid_ram (
    .clk   (clk),
    .we    (load_wr),
    .waddr (ADDR_W'(slot)),
    .wdata (valid_vec),
    .re    (rd_en),
    .raddr (ADDR_W'(mid_calc)),
    .rdata (ram_valid)
  );

  // Morton value of the query, taken when the search word is accepted.
  logic [MW-1:0]    q_val;
  logic [LEN_W-1:0] q_len;

  mops_expand #(
    .MAX_KEYS  (MAX_KEYS),
    .HASH_BITS (HASH_BITS),
    .VALID_W   (VALID_W),
    .KEY_W     (KEY_W),
    .LEN_W     (LEN_W)
  ) u_query_expand (
    .clk       (clk),
    .load      (query_load),
    .key_num   (key_num),
    .hash_vec  (hash_vec),
    .valid_vec (valid_vec),
    .morton    (q_val),
    .len       (q_len)
  );

  // Morton value of the probed entry, taken the cycle after the read.
  logic [MW-1:0]    e_val;
  logic [LEN_W-1:0] e_len;

  mops_expand #(
    .MAX_KEYS  (MAX_KEYS),
    .HASH_BITS (HASH_BITS),
    .VALID_W   (VALID_W),
    .KEY_W     (KEY_W),
    .LEN_W     (LEN_W)
  ) u_entry_expand (
    .clk       (clk),
    .load      (state == ST_EXPAND),
    .key_num   (key_num),
    .hash_vec  (ram_hash),
    .valid_vec (ram_valid),
    .morton    (e_val),
    .len       (e_len)
  );

  // Compare the common valid prefix; under full compare the longer wins a tie.
  logic [LEN_W-1:0] min_len;
  logic [MW-1:0]    prefix_mask;
  logic [MW-1:0]    q_pre;
  logic [MW-1:0]    e_pre;
  logic             q_gt;
  logic             q_lt;

  always_comb begin
    min_len     = (q_len < e_len) ? q_len : e_len;
    prefix_mask = ~({MW{1'b1}} >> min_len);
    q_pre       = q_val & prefix_mask;
    e_pre       = e_val & prefix_mask;
    q_gt        = q_pre > e_pre;
    q_lt        = q_pre < e_pre;
    if ((q_pre == e_pre) && full_q) begin
      q_gt = q_len > e_len;
      q_lt = q_len < e_len;
    end
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    lo        <= lo_next;
    hx        <= hx_next;
    mid       <= mid_next;
    res_found <= res_found_next;
    res_pos   <= res_pos_next;
    if (query_load) begin
      full_q <= full_compare;
    end
  end

  // Next state: probe the middle of the open range until it is empty or hit.
  always_comb begin
    state_next     = state;
    lo_next        = lo;
    hx_next        = hx;
    mid_next       = mid;
    res_found_next = res_found;
    res_pos_next   = res_pos;
    rd_en          = 1'b0;
    out_load       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && (kind == KIND_SEARCH)) begin
          lo_next    = '0;
          hx_next    = count_sat;
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (lo < hx) begin
          rd_en      = 1'b1;
          mid_next   = mid_calc;
          state_next = ST_EXPAND;
        end else begin
          res_found_next = 1'b0;
          res_pos_next   = lo;
          state_next     = ST_DONE;
        end
      end
      ST_EXPAND: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (q_gt) begin
          lo_next    = mid + 1'b1;
          state_next = ST_PROBE;
        end else if (q_lt) begin
          hx_next    = mid;
          state_next = ST_PROBE;
        end else begin
          res_found_next = 1'b1;
          res_pos_next   = mid;
          state_next     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      found    <= res_found;
      position <= POS_W'(res_pos);
    end
  end

  // The probed index always lies inside the open range.
  a_mid_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXPAND) |-> ((lo <= mid) && (mid < hx)))
    else $error("probe index outside search range");

  // Every probe that misses narrows the range.
  a_range_shrinks: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_CMP) && (q_gt || q_lt)) |=>
      (({1'b0, hx} - {1'b0, lo}) < ({1'b0, $past(hx)} - {1'b0, $past(lo)})))
    else $error("search range did not shrink");

  // A finished result waits while the output register is held.
  a_done_waits: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DONE) && out_valid && out_stall) |=> (state == ST_DONE))
    else $error("result dropped while output stalled");

endmodule

`default_nettype wire
